@@ rtl/core/trw_pkg.sv @@
// ----------------------------------------------------------------------------
// trw_pkg
// shared constants, types and field layout of the wall column renderer
// ----------------------------------------------------------------------------
package trw_pkg;

  localparam int SCREEN_ROWS = 480;
  localparam int SCREEN_COLS = 640;
  localparam int TEX_SIZE    = 64;
  localparam int FACE_COUNT  = 4;
  localparam int TEX_BITS    = $clog2(TEX_SIZE);
  localparam int FACE_BITS   = $clog2(FACE_COUNT);
  localparam int STORE_DEPTH = FACE_COUNT * TEX_SIZE * TEX_SIZE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = 12;
  localparam int IN_W        = 248;
  localparam int OUT_W       = 48;
  localparam int DVD_W       = TEX_BITS + 17;
  localparam int CNT_W       = $clog2(DVD_W + 1);

  // action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // config register indexes
  localparam logic CFG_SKY    = 1'b0;
  localparam logic CFG_GROUND = 1'b1;

  // pixel classes
  typedef enum logic [1:0] {
    CLS_SKY,
    CLS_WALL,
    CLS_GROUND
  } cls_e;

  typedef struct packed {
    logic tex_wr;
    logic col_begin;
    logic div_step;
    logic pos_mul;
    logic tick;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic active;
    logic out_busy;
  } stat_t;

endpackage

@@ rtl/core/trw_ram.sv @@
// ----------------------------------------------------------------------------
// trw_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module trw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/trw_datapath.sv @@
// ----------------------------------------------------------------------------
// trw_datapath
// column setup arithmetic, step divider, row walk, texture store, output reg
// ----------------------------------------------------------------------------
module trw_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trw_pkg::cmd_t         cmd_i,
  output trw_pkg::stat_t        stat_o,
  input  logic [trw_pkg::IN_W-1:0] in_data_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [trw_pkg::OUT_W-1:0] out_data_o,
  output logic                  out_last_o
);
  import trw_pkg::*;

  // input fields
  logic [45:0]        texel_load;
  logic signed [11:0] col_in;
  logic               side_in;
  logic [31:0]        pos_x_in, pos_y_in, dist_in;
  logic signed [20:0] dir_x_in, dir_y_in;
  logic [15:0]        lh_in;
  logic signed [16:0] ws_in, we_in;

  assign texel_load = in_data_i[45:0];
  assign col_in     = in_data_i[57:46];
  assign side_in    = in_data_i[58];
  assign pos_x_in   = in_data_i[90:59];
  assign pos_y_in   = in_data_i[122:91];
  assign dir_x_in   = in_data_i[143:123];
  assign dir_y_in   = in_data_i[164:144];
  assign dist_in    = in_data_i[196:165];
  assign lh_in      = in_data_i[212:197];
  assign ws_in      = in_data_i[229:213];
  assign we_in      = in_data_i[246:230];

  logic [31:0] sky_q, ground_q;
  logic        mirror_q;
  logic [FACE_BITS-1:0] face_q;
  logic [15:0] base_q, lh_q, h_q;
  logic signed [53:0] prod_q;
  logic signed [16:0] ws_q, we_q;
  logic        wen_q;
  logic [DVD_W-1:0] dq_q;
  logic [15:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0] step_q, tpos_q;
  logic [ROW_W-1:0] row_q;
  logic        active_q;
  cls_e        cls_q;
  logic [ROW_W-1:0] orow_q;
  logic        olast_q, owen_q, ovalid_q;
  logic [31:0] ocolor_q;
  logic [31:0] rdata;
  logic [TEX_BITS-1:0] tcol_q;

  // hit fraction and texture column
  logic [31:0] frac;
  logic [TEX_BITS-1:0] tcol_raw, tcol;
  assign frac     = {base_q, 16'h0} + prod_q[31:0];
  assign tcol_raw = frac[31 -: TEX_BITS];
  assign tcol     = mirror_q ? ~tcol_raw : tcol_raw;

  // restoring divider step
  logic [16:0] trial;
  logic        qbit;
  assign trial = {rem_q, dq_q[DVD_W-1]};
  assign qbit  = trial >= {1'b0, h_q};

  // start position term, scaled by the finished quotient
  logic [15:0] first;
  logic signed [18:0] term;
  logic signed [43:0] pos_prod;
  assign first    = ws_q[16] ? 16'h0 : ws_q[15:0];
  assign term     = $signed({3'b0, first}) - $signed(19'(SCREEN_ROWS / 2))
                    + $signed({4'b0, lh_q[15:1]});
  assign pos_prod = term * $signed({1'b0, dq_q});

  // texture row from position, truncation toward zero
  logic [31:0] neg_p, ipart;
  assign neg_p = 32'h0 - tpos_q;
  assign ipart = tpos_q[31] ? (32'h0 - (neg_p >> 16)) : (tpos_q >> 16);

  // row class
  logic signed [16:0] row_s;
  cls_e cls_d;
  assign row_s = $signed({{(17-ROW_W){1'b0}}, row_q});
  always_comb begin
    priority if (row_s < ws_q) begin
      cls_d = CLS_SKY;
    end else if (row_s < we_q) begin
      cls_d = CLS_WALL;
    end else begin
      cls_d = CLS_GROUND;
    end
  end

  logic row_last;
  assign row_last = row_q == ROW_W'(SCREEN_ROWS - 1);

  logic [ADDR_W-1:0] raddr;
  assign raddr = {face_q, ipart[TEX_BITS-1:0], tcol_q};

  logic wr_ok;
  assign wr_ok = {1'b0, texel_load[45:32]} < 15'(STORE_DEPTH);

  trw_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_tex (
    .clk_i  (clk_i),
    .we_i   (cmd_i.tex_wr && wr_ok),
    .waddr_i(texel_load[32 +: ADDR_W]),
    .wdata_i(texel_load[31:0]),
    .re_i   (cmd_i.tick),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // column setup payload, divider steps, step capture, row tick capture and output color
  always_ff @(posedge clk_i) begin
    if (cmd_i.col_begin) begin
      base_q   <= side_in ? pos_x_in[15:0] : pos_y_in[15:0];
      prod_q   <= $signed({1'b0, dist_in}) * (side_in ? dir_x_in : dir_y_in);
      if (!side_in) begin
        face_q   <= (!dir_x_in[20] && |dir_x_in) ? 2'd3 : 2'd2;
        mirror_q <= !dir_x_in[20] && |dir_x_in;
      end else begin
        face_q   <= (!dir_y_in[20] && |dir_y_in) ? 2'd1 : 2'd0;
        mirror_q <= dir_y_in[20];
      end
      lh_q  <= lh_in;
      h_q   <= (lh_in == 16'h0) ? 16'h1 : lh_in;
      ws_q  <= ws_in;
      we_q  <= we_in;
      wen_q <= !col_in[11] && (col_in < $signed(12'(SCREEN_COLS)));
      dq_q  <= DVD_W'(TEX_SIZE) << 16;
      rem_q <= 16'h0;
    end
    if (cmd_i.div_step) begin
      rem_q <= qbit ? 16'(trial - {1'b0, h_q}) : trial[15:0];
      dq_q  <= {dq_q[DVD_W-2:0], qbit};
    end
    if (cmd_i.pos_mul) begin
      step_q <= 32'(dq_q);
    end
    if (cmd_i.tick) begin
      cls_q   <= cls_d;
      orow_q  <= row_q;
      olast_q <= row_last;
      owen_q  <= wen_q;
    end
    if (cmd_i.emit) begin
      unique case (cls_q)
        CLS_SKY:  ocolor_q <= sky_q;
        CLS_WALL: ocolor_q <= rdata;
        default:  ocolor_q <= ground_q;
      endcase
    end
  end

  // control part of the datapath and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      row_q    <= '0;
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
      tpos_q   <= '0;
      tcol_q   <= '0;
      sky_q    <= '0;
      ground_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SKY:    sky_q    <= cfg_data_i;
          CFG_GROUND: ground_q <= cfg_data_i;
          default:    sky_q    <= sky_q;
        endcase
      end
      if (cmd_i.col_begin) begin
        cnt_q    <= CNT_W'(DVD_W);
        active_q <= 1'b0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.pos_mul) begin
        tpos_q   <= 32'(pos_prod);
        tcol_q   <= tcol;
        row_q    <= '0;
        active_q <= 1'b1;
      end else if (cmd_i.tick) begin
        if (cls_d == CLS_WALL) begin
          tpos_q <= tpos_q + step_q;
        end
        if (row_last) begin
          row_q    <= '0;
          active_q <= 1'b0;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign stat_o.div_done = cnt_q == '0;
  assign stat_o.active   = active_q;
  assign stat_o.out_busy = ovalid_q && !out_ready_i;

  assign out_valid_o = ovalid_q;
  assign out_last_o  = olast_q;
  assign out_data_o  = {3'b0, owen_q, ocolor_q, orow_q};

endmodule

@@ rtl/core/trw_ctrl.sv @@
// ----------------------------------------------------------------------------
// trw_ctrl
// sequencer for texel loads, column setup and row ticks
// ----------------------------------------------------------------------------
module trw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     action_i,
  output logic           in_ready_o,
  input  trw_pkg::stat_t stat_i,
  output trw_pkg::cmd_t  cmd_o
);
  import trw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_FETCH
  } state_e;

  state_e state_q;
  logic   acc;

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.out_busy;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.tex_wr    = acc && (action_i == ACT_LOAD);
    cmd_o.col_begin = acc && (action_i == ACT_BEGIN);
    cmd_o.tick      = acc && (action_i == ACT_TICK) && stat_i.active;
    cmd_o.div_step  = (state_q == S_DIV) && !stat_i.div_done;
    cmd_o.pos_mul   = (state_q == S_MUL);
    cmd_o.emit      = (state_q == S_FETCH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.col_begin) begin
            state_q <= S_DIV;
          end else if (cmd_o.tick) begin
            state_q <= S_FETCH;
          end
        end
        S_DIV: begin
          if (stat_i.div_done) begin
            state_q <= S_MUL;
          end
        end
        S_MUL:   state_q <= S_IDLE;
        S_FETCH: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/textured_wall_column_renderer.sv @@
// ----------------------------------------------------------------------------
// textured_wall_column_renderer
// raycaster wall column: texture store, column setup and per-row pixel stream
// ----------------------------------------------------------------------------
// A row tick transaction reads the texture store, then loads the output
// register; no input is taken until that pixel is registered. A texel load
// is written when taken. A begin column latches and multiplies, runs the
// bit-serial step divider (one quotient bit a cycle), then the start position
// multiply. The output register lets the next transaction in while the last
// pixel waits, unless that pixel is stalled. Row ticks with no column are
// taken and dropped. The texture store has no clear; read only written texels.
module textured_wall_column_renderer (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // texel_load, column, side, pos_x, pos_y, dir_x, dir_y, wall_distance,
  // line_height, wall_start, wall_end (low bits first)
  input  logic [trw_pkg::IN_W-1:0] s_axis_tdata,
  // action
  input  logic [1:0]   s_axis_tuser,
  // master stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // row, color, write_enable (low bits first)
  output logic [trw_pkg::OUT_W-1:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // config write port: 0 sky fill color, 1 floor fill color
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import trw_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  trw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .action_i  (s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // arithmetic, store and output register
  trw_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

@@ rtl/core/trw_checker.sv @@
// ----------------------------------------------------------------------------
// trw_checker
// port level checks of the wall column renderer, bound to the top level
// ----------------------------------------------------------------------------
module trw_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [trw_pkg::OUT_W-1:0] m_axis_tdata,
  input logic         m_axis_tlast
);
  import trw_pkg::*;

  // stalled pixel holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled pixel changed");

  // last flag only on the bottom row
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[ROW_W-1:0] == ROW_W'(SCREEN_ROWS - 1))
    else $error("last flag on wrong row");

  // no input taken while a pixel is stalled
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken under output stall");

  // column setup blocks the input
  a_begin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_BEGIN |=> !s_axis_tready)
    else $error("input ready during column setup");

endmodule

bind textured_wall_column_renderer trw_checker u_trw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

@@ sim/textured_wall_column_renderer_test.sv @@
// ----------------------------------------------------------------------------
// textured_wall_column_renderer_test
// drives texel loads, column setups and row ticks through the stream ports,
// predicts each pixel and compares it with what the renderer streams out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// pixel predictor and queue of expected pixels
class pixel_scoreboard;
  logic [31:0] texels [trw_pkg::STORE_DEPTH];
  bit          written [trw_pkg::STORE_DEPTH];
  logic [31:0] sky, ground;
  logic [12:0] row_cnt;
  bit          active;
  logic [31:0] tex_pos, tex_step;
  logic [5:0]  tex_col;
  logic [1:0]  face;
  int          slice_lo, slice_hi;
  int          scr_col;
  logic [47:0] pending_px [$];
  bit          pending_last [$];
  int          n_err;

  function new();
    sky = 0; ground = 0; row_cnt = 0; active = 0; tex_pos = 0; tex_step = 0;
    tex_col = 0; face = 0; slice_lo = 0; slice_hi = 0; scr_col = 0; n_err = 0;
    foreach (written[i]) written[i] = 0;
  endfunction

  // walks one row tick; gives the texel address read, or -1 for none
  function int next_read();
    int r, a;
    logic [31:0] p, ip;
    a = -1;
    if (!active) return -1;
    r = row_cnt;
    if (r >= slice_lo && r < slice_hi) begin
      p = tex_pos;
      // integer part truncated toward zero
      ip = p[31] ? 32'd0 - ((32'd0 - p) >> 16) : p >> 16;
      tex_pos = p + tex_step;
      a = int'({face, ip[5:0], tex_col});
    end
    if (row_cnt + 1 >= trw_pkg::SCREEN_ROWS) begin
      active = 0; row_cnt = 0;
    end else row_cnt = row_cnt + 1;
    return a;
  endfunction

  function void note_input(logic [1:0] act, logic [247:0] d);
    logic [13:0] addr;
    logic signed [11:0] col;
    logic side;
    logic [31:0] px, py, wdist;
    logic signed [20:0] dx, dy;
    logic [15:0] lh;
    logic signed [16:0] ws, we;
    logic [63:0] base, prod, frac, tc;
    longint sprod, term, first, h;
    logic [31:0] color;
    logic [11:0] rw;
    bit lst;
    int r, a;
    if (act == trw_pkg::ACT_LOAD) begin
      addr = d[45:32];
      if (addr < trw_pkg::STORE_DEPTH) begin
        texels[addr] = d[31:0];
        written[addr] = 1;
      end
    end else if (act == trw_pkg::ACT_BEGIN) begin
      col = d[57:46]; side = d[58]; px = d[90:59]; py = d[122:91];
      dx = d[143:123]; dy = d[164:144]; wdist = d[196:165]; lh = d[212:197];
      ws = d[229:213]; we = d[246:230];
      if (side == 0) begin
        face = dx > 0 ? 2'd3 : 2'd2;
        base = {32'd0, py};
        sprod = longint'(wdist) * longint'(dy);
      end else begin
        face = dy > 0 ? 2'd1 : 2'd0;
        base = {32'd0, px};
        sprod = longint'(wdist) * longint'(dx);
      end
      prod = sprod;
      frac = ((base << 16) + prod) & 64'hFFFF_FFFF;
      tc = (frac * 64) >> 32;
      if ((side == 0 && dx > 0) || (side == 1 && dy < 0)) tc = 63 - tc;
      tex_col = tc[5:0];
      h = (lh == 0) ? 1 : lh;
      tex_step = (64 << 16) / h;
      first = ws < 0 ? 0 : ws;
      term = first - trw_pkg::SCREEN_ROWS / 2 + lh / 2;
      tex_pos = term * longint'(tex_step);
      slice_lo = ws; slice_hi = we; scr_col = col;
      row_cnt = 0; active = 1;
    end else if (act == trw_pkg::ACT_TICK && active) begin
      r = row_cnt;
      rw = row_cnt[11:0];
      lst = (row_cnt + 1 >= trw_pkg::SCREEN_ROWS);
      a = next_read();
      if (a >= 0) color = texels[a];
      else if (r < slice_lo) color = sky;
      else color = ground;
      pending_px.push_back(48'({(scr_col >= 0 && scr_col < trw_pkg::SCREEN_COLS),
                                color, rw}));
      pending_last.push_back(lst);
    end
  endfunction

  function void check_pixel(logic [47:0] d, logic lst);
    logic [47:0] e;
    bit el;
    if (pending_px.size() == 0) begin
      $error("unexpected pixel row %0d", d[11:0]);
      n_err++;
      return;
    end
    e = pending_px.pop_front();
    el = pending_last.pop_front();
    if (d[11:0] !== e[11:0]) begin
      $error("row: expected %0d actual %0d", e[11:0], d[11:0]); n_err++;
    end
    if (d[43:12] !== e[43:12]) begin
      $error("color: expected %h actual %h", e[43:12], d[43:12]); n_err++;
    end
    if (d[44] !== e[44]) begin
      $error("write_enable: expected %0d actual %0d", e[44], d[44]); n_err++;
    end
    if (lst !== el) begin
      $error("last: expected %0d actual %0d", el, lst); n_err++;
    end
  endfunction
endclass

module textured_wall_column_renderer_test;
  import trw_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam logic [1:0] ACT_UNDEF = 2'd3;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = ACT_LOAD;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we_i = 0;
  logic cfg_idx_i = CFG_SKY;
  logic [31:0] cfg_data_i = '0;

  pixel_scoreboard sb = new();
  // walks a column ahead of time to find the texels it will read
  pixel_scoreboard planner = new();
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int stall_cnt = 0;
  int items = 0;
  int ph_end;

  always #1 clk_i = ~clk_i;

  textured_wall_column_renderer u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // output side: random back-pressure and pixel checking
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cnt <= 0;
    else if (rst_ni) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WATCHDOG) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // one transaction on the slave side, with optional idle gaps in front;
  // valid stays up until the next idle gap or drain
  task automatic send_item(input logic [1:0] act, input logic [IN_W-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= act;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(act, d);
    items++;
  endtask

  task automatic load_texel(input int addr, input logic [31:0] color);
    logic [IN_W-1:0] d;
    d = '0;
    d[45:32] = 14'(addr);
    d[31:0] = color;
    send_item(ACT_LOAD, d);
  endtask

  function automatic logic [IN_W-1:0] make_begin(
      input logic signed [11:0] col, input logic side,
      input logic [31:0] px, input logic [31:0] py,
      input logic signed [20:0] dx, input logic signed [20:0] dy,
      input logic [31:0] wdist, input logic [15:0] lh,
      input logic signed [16:0] ws, input logic signed [16:0] we);
    logic [IN_W-1:0] d;
    d = '0;
    d[45:0] = 46'({$urandom, $urandom});
    d[57:46] = col; d[58] = side; d[90:59] = px; d[122:91] = py;
    d[143:123] = dx; d[164:144] = dy; d[196:165] = wdist; d[212:197] = lh;
    d[229:213] = ws; d[246:230] = we; d[247] = 1'($urandom);
    return d;
  endfunction

  task automatic row_tick();
    logic [IN_W-1:0] d;
    d = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom});
    send_item(ACT_TICK, d);
  endtask

  // loads each texel the column will read that is not yet written, then begins it and sends n ticks
  task automatic run_column(input logic [IN_W-1:0] d, input int n);
    int a;
    planner.note_input(ACT_BEGIN, d);
    repeat (n) begin
      a = planner.next_read();
      if (a >= 0 && !sb.written[a]) load_texel(a, $urandom);
    end
    send_item(ACT_BEGIN, d);
    repeat (n) row_tick();
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == CFG_SKY) sb.sky = val; else sb.ground = val;
    @(posedge clk_i);
  endtask

  // random column, mostly in-range slices, often cut short by the next begin
  task automatic random_column();
    logic side;
    logic signed [20:0] dx, dy;
    logic signed [11:0] col;
    logic [15:0] lh;
    int ws, we;
    side = 1'($urandom);
    dx = 21'($urandom);
    dy = 21'($urandom);
    if ($urandom_range(3) == 0) dx = '0;
    if ($urandom_range(3) == 0) dy = '0;
    lh = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(600));
    ws = int'($urandom_range(700)) - 100;
    we = ws + int'($urandom_range(700)) - 50;
    if ($urandom_range(9) == 0) begin
      ws = int'($urandom_range(131071)) - 65536;
      we = int'($urandom_range(131071)) - 65536;
    end
    col = ($urandom_range(9) < 8) ? 12'($urandom_range(639)) : 12'($urandom);
    run_column(make_begin(col, side, $urandom, $urandom, dx, dy, $urandom, lh,
                          17'(ws), 17'(we)), int'($urandom_range(30)));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // ---- directed part
    write_cfg(CFG_SKY, 32'h0000_0000);
    write_cfg(CFG_GROUND, 32'hFFFF_FFFF);
    // row tick with no column is dropped; undefined action does nothing
    row_tick();
    send_item(ACT_UNDEF, '1);
    // top texel address of the store, then address zero
    load_texel(16383, 32'hDEAD_BEEF);
    load_texel(0, 32'h0);
    // start above row 0, extreme line height 0, negative column
    run_column(make_begin(12'h800, 1'b1, 32'hFFFF_FFFF, 32'h0, 21'h100000, -21'sd5,
                          32'hFFFF_FFFF, 16'd0, 17'h10000, 17'sd65535), 10);
    // begin during a column restarts at row 0; empty wall, side 0 mirrored
    run_column(make_begin(12'sd639, 1'b0, 32'h0, 32'hFFFF_FFFF, 21'sd1048575,
                          21'sd1048575, 32'h0, 16'hFFFF, 17'sd300, 17'sd100),
               SCREEN_ROWS);
    drain();
    write_cfg(CFG_SKY, 32'hFFFF_FFFF);
    write_cfg(CFG_GROUND, 32'h0);
    run_column(make_begin(12'sd640, 1'b0, 32'h1234_5678, 32'h8000_0000, -21'sd3,
                          21'sd7, 32'h0003_0000, 16'd480, 17'sd0, 17'sd480), 60);
    // sender holds off until every pixel has come
    drain();

    // ---- random part, three idle profiles
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 58 : 0;
      snk_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 14 : 0;
      write_cfg(CFG_SKY, $urandom);
      write_cfg(CFG_GROUND, $urandom);
      ph_end = items + 60;
      while (items < ph_end) begin
        repeat ($urandom_range(3)) load_texel(int'($urandom_range(16383)), $urandom);
        random_column();
        if ($urandom_range(4) == 0) send_item(ACT_UNDEF, IN_W'({$urandom, $urandom}));
      end
      drain();
    end

    if (sb.n_err == 0 && sb.pending_px.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/trw_pkg.sv
rtl/core/trw_ram.sv
rtl/core/trw_datapath.sv
rtl/core/trw_ctrl.sv
rtl/core/textured_wall_column_renderer.sv
rtl/core/trw_checker.sv
sim/textured_wall_column_renderer_test.sv
